// ===== design/reflow_profile_pid_heater_defines.svh =====
// assertion helpers for the checker file
`ifndef REFLOW_PROFILE_PID_HEATER_DEFINES_SVH
`define REFLOW_PROFILE_PID_HEATER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define RPPID_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define RPPID_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rppid_pkg.sv =====
package rppid_pkg;

  localparam int MAX_STAGES = 5;
  localparam int TEMP_BITS  = 12;
  localparam int SP_BITS    = 12;
  localparam int RAW_BITS   = 16;
  localparam int TEMP_LSB   = 3;
  localparam int GAIN_BITS  = 16;
  localparam int STAGE_BITS = 3;
  localparam int SETPT_BITS = SP_BITS * MAX_STAGES;
  localparam int ERR_BITS   = SP_BITS + 1;
  localparam int INTEG_BITS = 48;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 60;
  localparam int OUT_DATA_BITS = 24;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_SETPOINTS   = 3'd3,
    REG_STAGE_COUNT = 3'd4,
    REG_START_LIMIT = 3'd5
  } reg_idx_t;

  localparam logic [GAIN_BITS-1:0]  RST_PROP_GAIN   = 16'd33;
  localparam logic [GAIN_BITS-1:0]  RST_INTEG_GAIN  = 16'd7;
  localparam logic [GAIN_BITS-1:0]  RST_DERIV_GAIN  = 16'd66;
  localparam logic [SETPT_BITS-1:0] RST_SETPOINTS   = 60'd191467592754757992;
  localparam logic [STAGE_BITS-1:0] RST_STAGE_COUNT = 3'd5;
  localparam logic [TEMP_BITS-1:0]  RST_START_LIMIT = 12'd400;

  localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
  localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

  typedef struct packed {
    logic [GAIN_BITS-1:0]  prop_gain;
    logic [GAIN_BITS-1:0]  integ_gain;
    logic [GAIN_BITS-1:0]  deriv_gain;
    logic [SETPT_BITS-1:0] stage_setpoints;
    logic [STAGE_BITS-1:0] stage_count;
    logic [TEMP_BITS-1:0]  start_limit;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0]  temperature;
    logic                  start_refused;
    logic                  profile_done;
    logic [STAGE_BITS-1:0] stage;
    logic                  running;
    logic                  heater_on;
  } result_t;

endpackage

// ===== design/reflow_profile_pid_heater.sv =====
// channel  direction  handshake           payload
// in_      slave      in_tvalid/tready    tuser command, tdata raw converter word
// out_     master     out_tvalid/tready   tdata status and temperature, tlast profile done
// cfg_     slave      cfg_valid/ready     cfg_index register, cfg_data value
//
// one request per cycle sustained while out_tready stays high; a result passes
// through the input register, the pid step and the result register, in that order
// the result register frees the input side while a finished result waits
// rst_n is synchronous active low; all handshakes are held off during reset
// a stalled out_tready backs up into in_tready only once both registers hold data
module reflow_profile_pid_heater
  import rppid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [1:0]               in_tuser,   // [1:0] command
  input  logic [RAW_BITS-1:0]      in_tdata,   // [15:0] raw_sample
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [0] heater_on, [1] running, [4:2] stage, [5] start_refused,
  // [17:6] temperature, [23:18] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast,  // profile_done
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // heater, running, stage, refused and temperature bits in tdata
  localparam int TDATA_USED = TEMP_BITS + STAGE_BITS + 3;

  cfg_t    cfg;
  result_t res;

  // input register
  logic                in_vld_r;
  logic [1:0]          in_cmd_r;
  logic [RAW_BITS-1:0] in_raw_r;

  // result register
  logic                out_vld_r;
  result_t             out_res_r;

  logic advance;   // the held request is processed and moves to the result register
  logic in_take;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = rst_n && (!in_vld_r || advance);
  assign in_take   = in_tvalid && in_tready;

  rppid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pid step; state registers update when the request moves on
  rppid_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cmd     (in_cmd_r),
    .raw     (in_raw_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= in_tuser;
      in_raw_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_res_r.profile_done;
  assign out_tdata  = {{(OUT_DATA_BITS-TDATA_USED){1'b0}}, out_res_r.temperature,
                       out_res_r.start_refused, out_res_r.stage, out_res_r.running,
                       out_res_r.heater_on};

endmodule

// ===== design/rppid_cfg.sv =====
module rppid_cfg
  import rppid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  logic ready_r;
  logic wr_en;

  assign wr_en     = cfg_valid && ready_r;
  assign cfg_ready = ready_r;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r               <= 1'b0;
      cfg_r.prop_gain       <= RST_PROP_GAIN;
      cfg_r.integ_gain      <= RST_INTEG_GAIN;
      cfg_r.deriv_gain      <= RST_DERIV_GAIN;
      cfg_r.stage_setpoints <= RST_SETPOINTS;
      cfg_r.stage_count     <= RST_STAGE_COUNT;
      cfg_r.start_limit     <= RST_START_LIMIT;
    end else begin
      ready_r <= 1'b1;
      if (wr_en) begin
        unique case (cfg_index)
          REG_PROP_GAIN:   cfg_r.prop_gain       <= cfg_data[GAIN_BITS-1:0];
          REG_INTEG_GAIN:  cfg_r.integ_gain      <= cfg_data[GAIN_BITS-1:0];
          REG_DERIV_GAIN:  cfg_r.deriv_gain      <= cfg_data[GAIN_BITS-1:0];
          REG_SETPOINTS:   cfg_r.stage_setpoints <= cfg_data[SETPT_BITS-1:0];
          REG_STAGE_COUNT: cfg_r.stage_count     <= cfg_data[STAGE_BITS-1:0];
          REG_START_LIMIT: cfg_r.start_limit     <= cfg_data[TEMP_BITS-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
    end
  end

endmodule

// ===== design/rppid_core.sv =====
module rppid_core
  import rppid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [1:0]          cmd,
  input  logic [RAW_BITS-1:0] raw,
  input  cfg_t                cfg,
  output result_t             res
);

  localparam int PROD_BITS = GAIN_BITS + ERR_BITS + 1;

  logic                         active_r, active_nxt;
  logic [STAGE_BITS-1:0]        stage_r, stage_nxt;
  logic signed [INTEG_BITS-1:0] integ_r, integ_nxt;
  logic signed [ERR_BITS-1:0]   prev_err_r, prev_err_nxt;
  logic                         heater_r, heater_nxt;

  logic [TEMP_BITS-1:0]         temp;
  logic [STAGE_BITS-1:0]        n_use;
  logic [STAGE_BITS-1:0]        stage_inc;
  logic [SP_BITS-1:0]           sp;
  logic signed [ERR_BITS-1:0]   err;
  logic signed [ERR_BITS:0]     derr;
  logic signed [GAIN_BITS+ERR_BITS:0]   p_term;
  logic signed [GAIN_BITS+ERR_BITS:0]   i_inc;
  logic signed [GAIN_BITS+ERR_BITS+1:0] d_term;
  logic signed [INTEG_BITS:0]   s_wide;
  logic signed [INTEG_BITS-1:0] s_sat;
  logic signed [INTEG_BITS+1:0] total;
  logic                         sum_pos;
  logic                         done;
  logic                         refused;

  assign temp      = raw[TEMP_LSB +: TEMP_BITS];
  assign n_use     = (cfg.stage_count > STAGE_BITS'(MAX_STAGES)) ?
                     STAGE_BITS'(MAX_STAGES) : cfg.stage_count;
  assign stage_inc = stage_r + STAGE_BITS'(1);

  // setpoint of the current stage
  always_comb begin
    sp = '0;
    for (int k = 0; k < MAX_STAGES; k++) begin
      if (stage_r == STAGE_BITS'(k)) begin
        sp = cfg.stage_setpoints[k*SP_BITS +: SP_BITS];
      end
    end
  end

  // error terms and the control sum as signed integer counts
  always_comb begin
    err    = $signed({1'b0, sp}) - $signed({1'b0, temp});
    derr   = $signed({prev_err_r[ERR_BITS-1], prev_err_r}) - $signed({err[ERR_BITS-1], err});
    p_term = PROD_BITS'($signed({1'b0, cfg.prop_gain})) * PROD_BITS'(err);
    i_inc  = PROD_BITS'($signed({1'b0, cfg.integ_gain})) * PROD_BITS'(err);
    d_term = (PROD_BITS+1)'($signed({1'b0, cfg.deriv_gain})) * (PROD_BITS+1)'(derr);
    s_wide = (INTEG_BITS+1)'(integ_r) + (INTEG_BITS+1)'(i_inc);
    if (s_wide[INTEG_BITS] != s_wide[INTEG_BITS-1]) begin
      s_sat = s_wide[INTEG_BITS] ? INTEG_MIN : INTEG_MAX;
    end else begin
      s_sat = s_wide[INTEG_BITS-1:0];
    end
    total   = (INTEG_BITS+2)'(p_term) + (INTEG_BITS+2)'(s_sat) + (INTEG_BITS+2)'(d_term);
    sum_pos = !total[INTEG_BITS+1] && (|total);
  end

  always_comb begin
    active_nxt   = active_r;
    stage_nxt    = stage_r;
    integ_nxt    = integ_r;
    prev_err_nxt = prev_err_r;
    heater_nxt   = heater_r;
    done         = 1'b0;
    refused      = 1'b0;
    case (cmd)
      CMD_START: begin
        if (temp > cfg.start_limit) begin
          refused = 1'b1;
        end else begin
          stage_nxt    = '0;
          integ_nxt    = '0;
          prev_err_nxt = '0;
          active_nxt   = 1'b1;
          if (n_use == '0) begin
            heater_nxt = 1'b0;
            active_nxt = 1'b0;
            done       = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        heater_nxt = 1'b0;
        active_nxt = 1'b0;
      end
      CMD_SAMPLE: begin
        if (active_r) begin
          if (stage_r >= n_use) begin
            heater_nxt = 1'b0;
            active_nxt = 1'b0;
            done       = 1'b1;
          end else begin
            integ_nxt    = s_sat;
            heater_nxt   = sum_pos;
            prev_err_nxt = err;
            if (err[ERR_BITS-1] || (err == '0)) begin
              stage_nxt    = stage_inc;
              integ_nxt    = '0;
              prev_err_nxt = '0;
              if (stage_inc >= n_use) begin
                heater_nxt = 1'b0;
                active_nxt = 1'b0;
                done       = 1'b1;
              end
            end
          end
        end
      end
      default: ;  // unused command, state kept
    endcase
  end

  always_comb begin
    res.heater_on     = heater_nxt;
    res.running       = active_nxt;
    res.stage         = stage_nxt;
    res.profile_done  = done;
    res.start_refused = refused;
    res.temperature   = temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      stage_r    <= '0;
      integ_r    <= '0;
      prev_err_r <= '0;
      heater_r   <= 1'b0;
    end else if (step_en) begin
      active_r   <= active_nxt;
      stage_r    <= stage_nxt;
      integ_r    <= integ_nxt;
      prev_err_r <= prev_err_nxt;
      heater_r   <= heater_nxt;
    end
  end

endmodule

// ===== design/rppid_chk.sv =====
`include "reflow_profile_pid_heater_defines.svh"

module rppid_chk
  import rppid_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tlast
);

  `RPPID_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `RPPID_ASSERT_IMP(a_heat_run, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[1], "heater on while not running")
  `RPPID_ASSERT_IMP(a_done_off, clk, rst_n, out_tvalid && out_tlast, !out_tdata[1] && !out_tdata[0] && !out_tdata[5], "profile done with heater or run still set")
  `RPPID_ASSERT_IMP(a_stage_rng, clk, rst_n, out_tvalid, out_tdata[4:2] != 3'd6 && out_tdata[4:2] != 3'd7, "stage index out of range")

endmodule

bind reflow_profile_pid_heater rppid_chk u_rppid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rppid_pkg::*;

  // command code that the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 60_000;
  localparam int IDLE_PCT    = 18;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [1:0]               in_tuser = CMD_SAMPLE;  // [1:0] command
  logic [RAW_BITS-1:0]      in_tdata = '0;          // [15:0] raw_sample
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // [0] heater_on, [1] running, [4:2] stage, [5] start_refused,
  // [17:6] temperature, [23:18] zero
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;              // profile_done
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_PROP_GAIN;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // when set, neither side idles
  bit steady = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  // controller status expected on the result channel, oldest first
  result_t expected_status[$];

  // shadow of the controller: settings and profile state
  cfg_t        ctl_cfg = '{RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                           RST_SETPOINTS, RST_STAGE_COUNT, RST_START_LIMIT};
  logic        ctl_active = 1'b0;
  logic        ctl_heater = 1'b0;
  logic [2:0]  ctl_stage = '0;
  longint      ctl_integ = 0;
  int          ctl_prev_err = 0;

  reflow_profile_pid_heater uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one control step of the oven controller; updates the shadow state and
  // returns the status that the block must report for this request
  function automatic result_t step_controller(logic [1:0] cmd, logic [RAW_BITS-1:0] raw);
    result_t     r;
    logic [11:0] temp;
    int          n;
    int          err;
    longint      p, inc, d, s;
    logic        done, refused;
    temp = raw[TEMP_LSB +: TEMP_BITS];
    done = 1'b0;
    refused = 1'b0;
    // stage counts past the table size fall back to the full table
    n = (ctl_cfg.stage_count > MAX_STAGES) ? MAX_STAGES : int'(ctl_cfg.stage_count);
    case (cmd)
      CMD_START: begin
        if (temp > ctl_cfg.start_limit) begin
          refused = 1'b1;
        end else begin
          ctl_stage = '0;
          ctl_integ = 0;
          ctl_prev_err = 0;
          ctl_active = 1'b1;
          // empty profile completes at once
          if (n == 0) begin
            ctl_heater = 1'b0;
            ctl_active = 1'b0;
            done = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        ctl_heater = 1'b0;
        ctl_active = 1'b0;
      end
      CMD_SAMPLE: begin
        if (ctl_active) begin
          if (ctl_stage >= n) begin
            // stage count shrank under a running profile
            ctl_heater = 1'b0;
            ctl_active = 1'b0;
            done = 1'b1;
          end else begin
            err = int'(ctl_cfg.stage_setpoints[ctl_stage*SP_BITS +: SP_BITS]) - int'(temp);
            p = longint'(ctl_cfg.prop_gain) * err;
            inc = longint'(ctl_cfg.integ_gain) * err;
            d = longint'(ctl_cfg.deriv_gain) * (longint'(ctl_prev_err) - err);
            s = ctl_integ + inc;
            if (s > longint'(INTEG_MAX)) s = longint'(INTEG_MAX);
            if (s < longint'(INTEG_MIN)) s = longint'(INTEG_MIN);
            ctl_integ = s;
            ctl_heater = (p + s + d) > 0;
            ctl_prev_err = err;
            // setpoint reached: next stage with a fresh integral
            if (err <= 0) begin
              ctl_stage = ctl_stage + 3'd1;
              ctl_integ = 0;
              ctl_prev_err = 0;
              if (ctl_stage >= n) begin
                ctl_heater = 1'b0;
                ctl_active = 1'b0;
                done = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.heater_on = ctl_heater;
    r.running = ctl_active;
    r.stage = ctl_stage;
    r.profile_done = done;
    r.start_refused = refused;
    r.temperature = temp;
    return r;
  endfunction

  // converter word for a temperature, with random bits around it
  function automatic logic [RAW_BITS-1:0] make_raw(int t);
    logic [11:0] tv;
    tv = t[11:0];
    return {1'($urandom_range(0, 1)), tv, 3'($urandom_range(0, 7))};
  endfunction

  function automatic cfg_t profile_settings(logic [15:0] kp, logic [15:0] ki,
                                            logic [15:0] kd, logic [59:0] sp,
                                            logic [2:0] cnt, logic [11:0] lim);
    cfg_t c;
    c.prop_gain = kp;
    c.integ_gain = ki;
    c.deriv_gain = kd;
    c.stage_setpoints = sp;
    c.stage_count = cnt;
    c.start_limit = lim;
    return c;
  endfunction

  function automatic logic [15:0] rand_gain();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hffff;
    if (pick < 6) return 16'($urandom_range(0, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // one request on the input channel, with random idle cycles ahead of it;
  // in_tvalid stays high for a following request
  task automatic send_request(input logic [1:0] cmd, input logic [RAW_BITS-1:0] raw);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_status.push_back(step_controller(cmd, raw));
  endtask

  // stop sending and let every pending result come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    // pipeline is two registers deep
    repeat (3) @(posedge clk);
  endtask

  // writes all six registers back to back, after draining every pending result
  task automatic load_settings(input cfg_t c);
    logic [CFG_DATA_BITS-1:0] value;
    drain_results();
    for (int i = REG_PROP_GAIN; i <= REG_START_LIMIT; i++) begin
      case (reg_idx_t'(i))
        REG_PROP_GAIN:   value = CFG_DATA_BITS'(c.prop_gain);
        REG_INTEG_GAIN:  value = CFG_DATA_BITS'(c.integ_gain);
        REG_DERIV_GAIN:  value = CFG_DATA_BITS'(c.deriv_gain);
        REG_SETPOINTS:   value = c.stage_setpoints;
        REG_STAGE_COUNT: value = CFG_DATA_BITS'(c.stage_count);
        REG_START_LIMIT: value = CFG_DATA_BITS'(c.start_limit);
        default:         value = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    ctl_cfg = c;
  endtask

  // reset settings: setpoints 360, 600, 732, 940, 680
  task automatic test_reset_profile();
    send_request(CMD_SAMPLE, 16'h0000);                  // sample while stopped
    send_request(CMD_UNUSED, 16'hffff);                  // unused code
    send_request(CMD_START, 16'hffff);                   // far too hot
    send_request(CMD_START, {1'b1, 12'd401, 3'b111});    // one count above limit
    send_request(CMD_START, {1'b1, 12'd400, 3'b111});    // exactly at limit
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(100));
    send_request(CMD_UNUSED, make_raw(100));
    send_request(CMD_START, make_raw(10));               // restart while running
    send_request(CMD_SAMPLE, make_raw(359));
    send_request(CMD_SAMPLE, make_raw(360));             // err zero advances
    send_request(CMD_SAMPLE, 16'h7fff);                  // err negative advances
    repeat (3) send_request(CMD_SAMPLE, make_raw(4095)); // runs to the end
    send_request(CMD_SAMPLE, make_raw(0));               // after completion
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(200));
    send_request(CMD_STOP, make_raw(200));               // stage kept
    send_request(CMD_SAMPLE, make_raw(200));
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_START, make_raw(4095));             // refused, still running
    send_request(CMD_SAMPLE, make_raw(0));
  endtask

  // empty, short and oversized profiles, and a profile shortened mid-run
  task automatic test_stage_counts();
    logic [2:0] counts [4];
    counts = '{3'd0, 3'd1, 3'd6, 3'd7};
    foreach (counts[j]) begin
      load_settings(profile_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                                     {5{12'd100}}, counts[j], 12'd4095));
      send_request(CMD_START, make_raw(0));
      send_request(CMD_SAMPLE, make_raw(50));
      repeat (6) send_request(CMD_SAMPLE, make_raw(150));
    end
    load_settings(profile_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                                   {5{12'd100}}, 3'd5, 12'd4095));
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(120));
    send_request(CMD_SAMPLE, make_raw(100));
    // stage two, but now only one stage in use
    load_settings(profile_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                                   {5{12'd100}}, 3'd1, 12'd4095));
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(0));
  endtask

  // gain, setpoint and start limit extremes
  task automatic test_gain_extremes();
    load_settings(profile_settings(16'hffff, 16'hffff, 16'hffff, {5{12'hfff}},
                                   3'd5, 12'd0));
    send_request(CMD_START, make_raw(1));
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(4094));
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(4095));
    load_settings(profile_settings(16'd0, 16'd0, 16'd0, 60'd0, 3'd5, 12'hfff));
    send_request(CMD_START, make_raw(4095));
    send_request(CMD_SAMPLE, make_raw(0));
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(0));
    // derivative alone: a falling error drives the sum up, a rising one down
    load_settings(profile_settings(16'd0, 16'd0, 16'hffff, {5{12'd2000}},
                                   3'd5, 12'hfff));
    send_request(CMD_START, make_raw(0));
    send_request(CMD_SAMPLE, make_raw(100));
    send_request(CMD_SAMPLE, make_raw(50));
    send_request(CMD_SAMPLE, make_raw(900));
    send_request(CMD_STOP, make_raw(900));
  endtask

  // random settings, mostly well-formed profile runs on a crude oven model
  task automatic test_random_profiles();
    cfg_t        c;
    logic [59:0] sp;
    int          oven;
    int          pick;
    for (int phase = 0; phase < 5; phase++) begin
      for (int s = 0; s < MAX_STAGES; s++) begin
        sp[s*SP_BITS +: SP_BITS] = ($urandom_range(0, 4) == 0) ?
          12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 1500));
      end
      c = profile_settings(rand_gain(), rand_gain(), rand_gain(), sp,
                           (phase == 0) ? 3'd5 : 3'($urandom_range(0, 7)),
                           12'($urandom_range(200, 4095)));
      load_settings(c);
      // one phase with both sides running flat out
      steady = (phase == 2);
      oven = $urandom_range(0, c.start_limit);
      for (int k = 0; k < 135; k++) begin
        pick = $urandom_range(0, 99);
        if (!ctl_active && pick < 60) begin
          oven = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, c.start_limit);
          send_request(CMD_START, make_raw(oven));
        end else if (pick < 3) begin
          send_request(CMD_STOP, make_raw(oven));
        end else if (pick < 5) begin
          send_request(CMD_UNUSED, 16'($urandom_range(0, 65535)));
        end else if (pick < 9) begin
          send_request(CMD_START, make_raw(oven));
        end else if (pick < 14) begin
          send_request(CMD_SAMPLE, 16'($urandom_range(0, 65535)));
        end else begin
          send_request(CMD_SAMPLE, make_raw(oven));
          // the oven follows the heater decision just predicted
          oven = ctl_heater ? oven + $urandom_range(0, 80) : oven - $urandom_range(0, 30);
          if (oven < 0) oven = 0;
          if (oven > 4095) oven = 4095;
        end
      end
    end
    steady = 1'b0;
  endtask

  // result checking against the oldest expected status
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("heater_on", 32'(want.heater_on), 32'(out_tdata[0]));
        check_field("running", 32'(want.running), 32'(out_tdata[1]));
        check_field("stage", 32'(want.stage), 32'(out_tdata[4:2]));
        check_field("profile_done", 32'(want.profile_done), 32'(out_tlast));
        check_field("start_refused", 32'(want.start_refused), 32'(out_tdata[5]));
        check_field("temperature", 32'(want.temperature), 32'(out_tdata[17:6]));
      end
    end
    // receiver stalls at random unless in a steady stretch
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_profile();
    test_stage_counts();
    test_gain_extremes();
    test_random_profiles();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
